FILE: design/i2crts_pkg.sv
`default_nettype none

package i2crts_pkg;

    // store depth default, and fixed field widths
    localparam int BUF_DEPTH_DEF = 32;
    localparam int CNT_W         = 6;
    localparam int IDX_W         = 5;

    // command codes
    localparam logic [2:0] CMD_START_RD = 3'd0;
    localparam logic [2:0] CMD_START_WR = 3'd1;
    localparam logic [2:0] CMD_LOAD_TX  = 3'd2;
    localparam logic [2:0] CMD_TX_READY = 3'd3;
    localparam logic [2:0] CMD_RX_BYTE  = 3'd4;
    localparam logic [2:0] CMD_READ_BK  = 3'd5;

    // sequencer modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_SEND_REG  = 3'd1;
    localparam logic [2:0] MODE_SWITCH_RX = 3'd2;
    localparam logic [2:0] MODE_SEND_DATA = 3'd3;
    localparam logic [2:0] MODE_RECV_DATA = 3'd4;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [6:0]       dev_address;
        logic [7:0]       register_address;
        logic [CNT_W-1:0] byte_count;
        logic [IDX_W-1:0] buffer_index;
        logic [7:0]       data_byte;
    } seq_in_t;

    typedef struct packed {
        logic       send_start;
        logic       receive_direction;
        logic [6:0] target_address;
        logic       send_stop;
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       transfer_done;
        logic [2:0] mode;
        logic [7:0] read_data;
    } seq_out_t;

endpackage

`default_nettype wire

FILE: design/i2c_register_transaction_sequencer.sv
// Latency: a result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; s_ready = !m_valid || m_ready.
// The result register and the registered read port of the two byte stores load on the same accept.
// Reset (aresetn low, synchronous): mode idle, latched addresses, counts and
// positions zero, output empty; store contents stay undefined until written.
`default_nettype none

module i2c_register_transaction_sequencer
    import i2crts_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire seq_in_t s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output seq_out_t     m_item
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW = $clog2(BUF_DEPTH + 1);
    localparam logic [PW-1:0]    DEPTH_P = PW'(BUF_DEPTH);
    localparam logic [8:0]       DEPTH_9 = 9'(BUF_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [PW-1:0]    POS_ONE = PW'(1);

    // sequencer state
    logic [2:0]       mode_reg, mode_next;
    logic [7:0]       lreg_reg, lreg_next;
    logic [6:0]       ldev_reg, ldev_next;
    logic [CNT_W-1:0] rx_rem_reg, rx_rem_next;
    logic [CNT_W-1:0] tx_rem_reg, tx_rem_next;
    logic [PW-1:0]    rx_pos_reg, rx_pos_next;
    logic [PW-1:0]    tx_pos_reg, tx_pos_next;

    // output register
    logic       out_vld_reg;
    seq_out_t   res_reg, res_next;
    logic       tx_mem_reg, tx_mem_next;
    logic       rd_mem_reg, rd_mem_next;

    // store controls
    logic            txs_we, txs_re, rxs_we, rxs_re;
    logic [AW-1:0]   txs_waddr, txs_raddr, rxs_waddr, rxs_raddr;
    logic [7:0]      txs_rdata, rxs_rdata;

    logic            accept;
    logic [CNT_W-1:0] clamped;
    logic            idx_ok;
    logic [CNT_W-1:0] rx_dec;

    assign s_ready = !out_vld_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_vld_reg;

    assign clamped = ({3'b000, s_item.byte_count} > DEPTH_9) ? CNT_W'(DEPTH_9)
                                                              : s_item.byte_count;
    assign idx_ok  = ({4'b0000, s_item.buffer_index} < DEPTH_9);
    assign rx_dec  = (rx_rem_reg != '0) ? rx_rem_reg - CNT_ONE : rx_rem_reg;

    // command decode and state update
    always_comb begin
        mode_next   = mode_reg;
        lreg_next   = lreg_reg;
        ldev_next   = ldev_reg;
        rx_rem_next = rx_rem_reg;
        tx_rem_next = tx_rem_reg;
        rx_pos_next = rx_pos_reg;
        tx_pos_next = tx_pos_reg;
        res_next    = '0;
        tx_mem_next = 1'b0;
        rd_mem_next = 1'b0;
        txs_we      = 1'b0;
        txs_re      = 1'b0;
        rxs_we      = 1'b0;
        rxs_re      = 1'b0;
        txs_waddr   = AW'(s_item.buffer_index);
        txs_raddr   = AW'(tx_pos_reg);
        rxs_waddr   = AW'(rx_pos_reg);
        rxs_raddr   = AW'(s_item.buffer_index);

        unique case (s_item.cmd)
            CMD_START_RD, CMD_START_WR: begin
                ldev_next   = s_item.dev_address;
                lreg_next   = s_item.register_address;
                rx_rem_next = (s_item.cmd == CMD_START_RD) ? clamped : '0;
                tx_rem_next = (s_item.cmd == CMD_START_WR) ? clamped : '0;
                rx_pos_next = '0;
                tx_pos_next = '0;
                mode_next   = MODE_SEND_REG;
                res_next.send_start     = 1'b1;
                res_next.target_address = s_item.dev_address;
            end
            CMD_LOAD_TX: begin
                txs_we = accept && idx_ok;
            end
            CMD_TX_READY: begin
                if (mode_reg == MODE_SEND_REG) begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_data  = lreg_reg;
                    mode_next = (rx_rem_reg != '0) ? MODE_SWITCH_RX : MODE_SEND_DATA;
                end else if (mode_reg == MODE_SWITCH_RX) begin
                    mode_next = MODE_RECV_DATA;
                    res_next.send_start        = 1'b1;
                    res_next.receive_direction = 1'b1;
                    res_next.target_address    = ldev_reg;
                    res_next.send_stop         = (rx_rem_reg == CNT_ONE);
                end else if (mode_reg == MODE_SEND_DATA) begin
                    if (tx_rem_reg != '0 && tx_pos_reg < DEPTH_P) begin
                        // byte comes from the transmit store next cycle
                        res_next.tx_valid = 1'b1;
                        tx_mem_next       = 1'b1;
                        txs_re            = accept;
                        tx_pos_next       = tx_pos_reg + POS_ONE;
                        tx_rem_next       = tx_rem_reg - CNT_ONE;
                    end else begin
                        res_next.send_stop     = 1'b1;
                        res_next.transfer_done = 1'b1;
                        mode_next              = MODE_IDLE;
                    end
                end
            end
            CMD_RX_BYTE: begin
                if (mode_reg == MODE_RECV_DATA) begin
                    if (rx_rem_reg != '0 && rx_pos_reg < DEPTH_P) begin
                        rxs_we      = accept;
                        rx_pos_next = rx_pos_reg + POS_ONE;
                    end
                    rx_rem_next = rx_dec;
                    if (rx_dec == CNT_ONE) begin
                        res_next.send_stop = 1'b1;
                    end else if (rx_dec == '0) begin
                        res_next.transfer_done = 1'b1;
                        mode_next              = MODE_IDLE;
                    end
                end
            end
            CMD_READ_BK: begin
                rd_mem_next = idx_ok;
                rxs_re      = accept && idx_ok;
            end
            default: begin
            end
        endcase

        res_next.mode = mode_next;
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            lreg_reg    <= '0;
            ldev_reg    <= '0;
            rx_rem_reg  <= '0;
            tx_rem_reg  <= '0;
            rx_pos_reg  <= '0;
            tx_pos_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                lreg_reg   <= lreg_next;
                ldev_reg   <= ldev_next;
                rx_rem_reg <= rx_rem_next;
                tx_rem_reg <= tx_rem_next;
                rx_pos_reg <= rx_pos_next;
                tx_pos_reg <= tx_pos_next;
            end
            if (s_ready) begin
                out_vld_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg    <= res_next;
            tx_mem_reg <= tx_mem_next;
            rd_mem_reg <= rd_mem_next;
        end
    end

    // stores; read data holds while the result waits
    i2crts_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_store (
        .aclk    (aclk),
        .wr_en   (txs_we),
        .wr_addr (txs_waddr),
        .wr_data (s_item.data_byte),
        .rd_en   (txs_re),
        .rd_addr (txs_raddr),
        .rd_data (txs_rdata)
    );

    i2crts_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_store (
        .aclk    (aclk),
        .wr_en   (rxs_we),
        .wr_addr (rxs_waddr),
        .wr_data (s_item.data_byte),
        .rd_en   (rxs_re),
        .rd_addr (rxs_raddr),
        .rd_data (rxs_rdata)
    );

    // result assembly
    always_comb begin
        m_item           = res_reg;
        m_item.tx_data   = tx_mem_reg ? txs_rdata : res_reg.tx_data;
        m_item.read_data = rd_mem_reg ? rxs_rdata : 8'h00;
    end

    // checks
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.transfer_done |-> m_item.mode == MODE_IDLE)
        else $error("transfer_done without idle mode");

    a_start_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_item.cmd == CMD_START_RD || s_item.cmd == CMD_START_WR)
        |=> mode_reg == MODE_SEND_REG)
        else $error("start did not enter send register mode");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_pos_reg <= DEPTH_P && tx_pos_reg <= DEPTH_P)
        else $error("store position past depth");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.tx_valid && m_item.send_start))
        else $error("start and byte in one result");

    a_mem_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(tx_mem_reg && rd_mem_reg))
        else $error("both stores selected for one result");

endmodule

`default_nettype wire

FILE: design/i2crts_ram.sv
`default_nettype none

module i2crts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
